/* hdl/mfld_pkg.sv */
package mfld_pkg;

    // fixed field widths
    localparam int COORD_W    = 12;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int DEC_W      = COORD_W + 3;
    localparam int OP_W       = 2;
    localparam int SW_W       = 9;
    localparam int SH_W       = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 64;

    // register reset values
    localparam logic [SW_W-1:0] SW_RESET = 9'd32;
    localparam logic [SH_W-1:0] SH_RESET = 7'd16;

    // register indexes (paddr bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // op codes
    localparam logic [OP_W-1:0] OP_READ = 2'd0;
    localparam logic [OP_W-1:0] OP_LINE = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL = 2'd2;

    // byte constants
    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;
    localparam logic [7:0] MSB_MASK   = 8'h80;
    localparam logic [2:0] BIT_SEL    = 3'h7;

    typedef logic signed [COORD_W-1:0] t_coord;

    // one pixel from the line stepper
    typedef struct packed {
        logic   vld;
        t_coord x;
        t_coord y;
    } t_pix;

    // screen size in use, saturated to the buffer size
    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_screen;

    // pixel bit within its byte, MSB first
    function automatic logic [7:0] bit_mask(input t_coord x);
        return MSB_MASK >> (x[2:0] & BIT_SEL);
    endfunction

endpackage

/* hdl/mfld_ram.sv */
module mfld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read of the address being written returns old data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

/* hdl/mfld_cfg.sv */
module mfld_cfg #(
    parameter int MAX_WIDTH  = mfld_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mfld_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfld_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mfld_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mfld_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output mfld_pkg::t_screen                   o_screen
);
    import mfld_pkg::*;

    localparam logic [COORD_W-1:0] MAX_W = COORD_W'(MAX_WIDTH);
    localparam logic [COORD_W-1:0] MAX_H = COORD_W'(MAX_HEIGHT);

    logic [SW_W-1:0]    r_sw;
    logic [SH_W-1:0]    r_sh;
    logic               wr_en;
    logic [COORD_W-1:0] sw_ext;
    logic [COORD_W-1:0] sh_ext;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, word decoded on address bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= SW_RESET;
            r_sh <= SH_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_WIDTH:  r_sw <= pwdata[SW_W-1:0];
                REG_HEIGHT: r_sh <= pwdata[SH_W-1:0];
                default:    r_sw <= r_sw;
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = CFG_DATA_W'(r_sw);
            REG_HEIGHT: prdata = CFG_DATA_W'(r_sh);
            default:    prdata = '0;
        endcase
    end

    // sizes in use, clipped to the buffer
    assign sw_ext = COORD_W'(r_sw);
    assign sh_ext = COORD_W'(r_sh);
    assign o_screen.width  = (sw_ext > MAX_W) ? MAX_W : sw_ext;
    assign o_screen.height = (sh_ext > MAX_H) ? MAX_H : sh_ext;

endmodule

/* hdl/mfld_line_step.sv */
module mfld_line_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mfld_pkg::t_coord i_x_start,
    input  mfld_pkg::t_coord i_y_start,
    input  mfld_pkg::t_coord i_x_end,
    input  mfld_pkg::t_coord i_y_end,
    output mfld_pkg::t_pix   o_pix,
    output logic             o_done
);
    import mfld_pkg::*;

    localparam logic [1:0] LS_IDLE  = 2'd0;
    localparam logic [1:0] LS_SETUP = 2'd1;
    localparam logic [1:0] LS_RUN   = 2'd2;

    logic [1:0]               r_state;
    logic                     r_pv;
    logic                     r_done;
    t_coord                   r_x, r_y, r_xe, r_ye;
    logic [COORD_W-1:0]       r_adx, r_ady;
    logic                     r_sx_neg, r_sy_neg;
    logic                     r_x_major;
    logic signed [DEC_W-1:0]  r_d, r_inc_s, r_inc_d;

    logic signed [DIFF_W-1:0] dx_fwd, dx_rev, dy_fwd, dy_rev;
    logic signed [DEC_W-1:0]  adx_s, ady_s;
    logic                     x_major;
    logic                     at_end;
    logic                     diag;
    t_coord                   x_step, y_step;

    // signed differences both ways, abs picked by sign
    assign dx_fwd = $signed({i_x_end[COORD_W-1], i_x_end})
                  - $signed({i_x_start[COORD_W-1], i_x_start});
    assign dx_rev = $signed({i_x_start[COORD_W-1], i_x_start})
                  - $signed({i_x_end[COORD_W-1], i_x_end});
    assign dy_fwd = $signed({i_y_end[COORD_W-1], i_y_end})
                  - $signed({i_y_start[COORD_W-1], i_y_start});
    assign dy_rev = $signed({i_y_start[COORD_W-1], i_y_start})
                  - $signed({i_y_end[COORD_W-1], i_y_end});

    // setup terms
    assign adx_s   = $signed({{(DEC_W-COORD_W){1'b0}}, r_adx});
    assign ady_s   = $signed({{(DEC_W-COORD_W){1'b0}}, r_ady});
    assign x_major = (r_adx >= r_ady);

    // step terms
    assign at_end = r_x_major ? (r_x == r_xe) : (r_y == r_ye);
    assign diag   = !r_d[DEC_W-1] && (r_d != '0);
    assign x_step = r_sx_neg ? (r_x - t_coord'(1)) : (r_x + t_coord'(1));
    assign y_step = r_sy_neg ? (r_y - t_coord'(1)) : (r_y + t_coord'(1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                LS_IDLE: begin
                    r_pv <= 1'b0;
                    if (i_load) begin
                        r_state <= LS_SETUP;
                    end
                end
                LS_SETUP: begin
                    r_pv    <= 1'b1;
                    r_state <= LS_RUN;
                end
                LS_RUN: begin
                    if (at_end) begin
                        r_pv    <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= LS_IDLE;
                    end else begin
                        r_pv <= 1'b1;
                    end
                end
                default: begin
                    r_pv    <= 1'b0;
                    r_state <= LS_IDLE;
                end
            endcase
        end
    end

    // datapath: load, decision setup, then one step per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == LS_IDLE && i_load) begin
            r_x      <= i_x_start;
            r_y      <= i_y_start;
            r_xe     <= i_x_end;
            r_ye     <= i_y_end;
            r_sx_neg <= dx_fwd[DIFF_W-1];
            r_sy_neg <= dy_fwd[DIFF_W-1];
            r_adx    <= dx_fwd[DIFF_W-1] ? dx_rev[COORD_W-1:0] : dx_fwd[COORD_W-1:0];
            r_ady    <= dy_fwd[DIFF_W-1] ? dy_rev[COORD_W-1:0] : dy_fwd[COORD_W-1:0];
        end else if (r_state == LS_SETUP) begin
            r_x_major <= x_major;
            if (x_major) begin
                r_d     <= (ady_s <<< 1) - adx_s;
                r_inc_s <= ady_s <<< 1;
                r_inc_d <= (ady_s - adx_s) <<< 1;
            end else begin
                r_d     <= (adx_s <<< 1) - ady_s;
                r_inc_s <= adx_s <<< 1;
                r_inc_d <= (adx_s - ady_s) <<< 1;
            end
        end else if (r_state == LS_RUN && !at_end) begin
            r_d <= diag ? (r_d + r_inc_d) : (r_d + r_inc_s);
            if (r_x_major) begin
                r_x <= x_step;
                if (diag) begin
                    r_y <= y_step;
                end
            end else begin
                r_y <= y_step;
                if (diag) begin
                    r_x <= x_step;
                end
            end
        end
    end

    assign o_pix.vld = r_pv;
    assign o_pix.x   = r_x;
    assign o_pix.y   = r_y;
    assign o_done    = r_done;

endmodule

/* hdl/mono_framebuffer_line_draw.sv */
// Monochrome frame buffer with line drawing, one bit per pixel, MSB first
// in each byte; a stored 1 is an unlit pixel.
// Command channel: an item (op, coordinates, pen color) is taken at a clock
// edge with start high and busy low. Every item gives exactly one result
// word on o_pixel_lit / o_off_screen, shown for one cycle with o_strobe
// high; the receiver cannot stall, and busy may drop during the strobe.
// Config: APB registers screen_width at 0x0 and screen_height at 0x4, to be
// written while the block is idle; pready is tied high.
// Steps from accept to strobe:
//   read pixel : address registered, memory read, result registered
//   draw line  : load, setup, then one pixel per cycle, each pixel a
//                read-modify-write of its byte with forwarding of the byte
//                written the cycle before
//   fill       : used_height * row_bytes bytes, one byte per memory write
//   op 3       : no memory access, result word only
// The single-write-port pixel memory sets the pace: one byte or pixel a
// cycle. After reset is released the block sweeps all MAX_HEIGHT * row_bytes
// bytes to all ones with busy high; register writes are taken during that sweep.
module mono_framebuffer_line_draw #(
    parameter int MAX_WIDTH  = mfld_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mfld_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [mfld_pkg::OP_W-1:0]        i_op,
    input  mfld_pkg::t_coord                 i_x_start,
    input  mfld_pkg::t_coord                 i_y_start,
    input  mfld_pkg::t_coord                 i_x_end,
    input  mfld_pkg::t_coord                 i_y_end,
    input  logic                             i_pen_color,
    // result
    output logic                             o_strobe,
    output logic                             o_pixel_lit,
    output logic                             o_off_screen,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mfld_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [mfld_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mfld_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import mfld_pkg::*;

    localparam int ROW_BYTES = (MAX_WIDTH + 7) / 8;
    localparam int DEPTH     = ROW_BYTES * MAX_HEIGHT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int XW        = $clog2(MAX_WIDTH + 1);
    localparam int YW        = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_RWAIT = 3'd3;
    localparam logic [2:0] ST_LINE  = 3'd4;
    localparam logic [2:0] ST_FILL  = 3'd5;

    // byte address of a pixel
    function automatic logic [AW-1:0] pix_addr(input t_coord x, input t_coord y);
        logic [XW-1:0] xi;
        logic [YW-1:0] yi;
        xi = x[XW-1:0];
        yi = y[YW-1:0];
        return AW'(yi * ROW_BYTES) + AW'(xi >> 3);
    endfunction

    function automatic logic on_screen(input t_coord x, input t_coord y,
                                       input t_screen scr);
        return !x[COORD_W-1] && !y[COORD_W-1] &&
               ($unsigned(x) < scr.width) && ($unsigned(y) < scr.height);
    endfunction

    t_screen     screen;
    t_pix        pix;
    logic        line_done;
    logic        accept;
    logic        line_load;

    logic [2:0]     r_state;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_lim;
    logic [7:0]     r_fill_byte;
    logic           r_pen;
    logic [AW-1:0]  r_rd_addr;
    logic [7:0]     r_rd_mask;
    logic           r_rd_off;
    logic           r_strobe;
    logic           r_pixel_lit;
    logic           r_off_screen;
    logic           r_s1_v;
    logic [AW-1:0]  r_s1_addr;
    logic [7:0]     r_s1_mask;
    logic           r_fw_v;
    logic [AW-1:0]  r_fw_addr;
    logic [7:0]     r_fw_data;

    logic           s0_hit;
    logic [AW-1:0]  s0_addr;
    logic [7:0]     rdata;
    logic [7:0]     base;
    logic [7:0]     line_wdata;
    logic           sweep;
    logic [CW-1:0]  sweep_lim;
    logic           sweep_end;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign line_load = accept && (i_op == OP_LINE);

    mfld_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_screen (screen)
    );

    mfld_line_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (line_load),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_pix     (pix),
        .o_done    (line_done)
    );

    // line stage 0: clip and issue the byte read
    assign s0_hit  = pix.vld && on_screen(pix.x, pix.y, screen);
    assign s0_addr = pix_addr(pix.x, pix.y);

    // line stage 1: modify, forwarding the byte written last cycle
    assign base       = (r_fw_v && (r_fw_addr == r_s1_addr)) ? r_fw_data : rdata;
    assign line_wdata = r_pen ? (base & ~r_s1_mask) : (base | r_s1_mask);

    // clear / fill sweep
    assign sweep     = (r_state == ST_CLEAR) || (r_state == ST_FILL);
    assign sweep_lim = (r_state == ST_CLEAR) ? CW'(DEPTH) : r_lim;
    assign sweep_end = (r_cnt == sweep_lim);

    // memory port muxing
    assign mem_we    = sweep ? !sweep_end : r_s1_v;
    assign mem_waddr = sweep ? r_cnt[AW-1:0] : r_s1_addr;
    assign mem_wdata = sweep ? r_fill_byte : line_wdata;
    assign mem_raddr = (r_state == ST_READ) ? r_rd_addr : s0_addr;

    mfld_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_fill_byte <= BYTE_ONES;
            r_strobe    <= 1'b0;
            r_s1_v      <= 1'b0;
            r_fw_v      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_s1_v   <= s0_hit;
            r_fw_v   <= r_s1_v;
            unique case (r_state)
                ST_CLEAR: begin
                    if (sweep_end) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (i_op)
                            OP_READ: r_state <= ST_READ;
                            OP_LINE: r_state <= ST_LINE;
                            OP_FILL: begin
                                r_state     <= ST_FILL;
                                r_cnt       <= '0;
                                r_fill_byte <= i_pen_color ? BYTE_ZEROS : BYTE_ONES;
                            end
                            default: r_strobe <= 1'b1;
                        endcase
                    end
                end
                ST_READ: r_state <= ST_RWAIT;
                ST_RWAIT: begin
                    r_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                ST_LINE: begin
                    if (line_done) begin
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_FILL: begin
                    if (sweep_end) begin
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pen     <= i_pen_color;
            r_rd_addr <= pix_addr(i_x_start, i_y_start);
            r_rd_mask <= bit_mask(i_x_start);
            r_rd_off  <= !on_screen(i_x_start, i_y_start, screen);
            r_lim     <= CW'(screen.height * ROW_BYTES);
        end
        r_s1_addr <= s0_addr;
        r_s1_mask <= bit_mask(pix.x);
        r_fw_addr <= r_s1_addr;
        r_fw_data <= line_wdata;
        // result fields are zero except for a pixel read
        if (r_state == ST_RWAIT) begin
            r_off_screen <= r_rd_off;
            r_pixel_lit  <= !r_rd_off && ((rdata & r_rd_mask) == BYTE_ZEROS);
        end else begin
            r_off_screen <= 1'b0;
            r_pixel_lit  <= 1'b0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_pixel_lit  = r_pixel_lit;
    assign o_off_screen = r_off_screen;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import mfld_pkg::*;

    localparam int MAX_W     = DEF_MAX_WIDTH;
    localparam int MAX_H     = DEF_MAX_HEIGHT;
    localparam int ROW_BYTES = (MAX_W + 7) / 8;
    localparam int FB_BYTES  = ROW_BYTES * MAX_H;
    localparam int N_PHASES  = 6;
    localparam int PHASE_CMDS = 272;
    localparam int N_PLAN    = 26;
    localparam int TAIL_CYCLES = 64;
    // Even if every command were a full-range line with the longest gaps,
    // the run stays under this limit.
    localparam int CYCLE_LIMIT = 40_000_000;

    // op code with no function; still answers with one word
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // one result word
    typedef struct packed {
        logic lit;
        logic off;
    } t_px_word;

    // one directed command, with an optional hand-written answer
    typedef struct {
        logic [OP_W-1:0] op;
        int              xs;
        int              ys;
        int              xe;
        int              ye;
        bit              pen;
        bit              typed;
        bit              lit;
        bit              off;
    } t_cmd_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       i_op;
    t_coord                i_x_start;
    t_coord                i_y_start;
    t_coord                i_x_end;
    t_coord                i_y_end;
    logic                  i_pen_color;
    logic                  o_strobe;
    logic                  o_pixel_lit;
    logic                  o_off_screen;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow frame buffer and screen size
    logic [7:0]  shadow_fb [0:FB_BYTES-1];
    int unsigned scr_w;
    int unsigned scr_h;

    t_px_word    pending_words[$];
    t_px_word    head_word;
    int          n_err;
    int          n_results;
    int          cycle_cnt;
    int          n_reads;
    int          n_lines;
    int          n_fills;
    int          n_spare;
    t_cmd_row    plan [N_PLAN];
    int unsigned phase_w [N_PHASES];
    int unsigned phase_h [N_PHASES];

    mono_framebuffer_line_draw dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_pen_color  (i_pen_color),
        .o_strobe     (o_strobe),
        .o_pixel_lit  (o_pixel_lit),
        .o_off_screen (o_off_screen),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ---------------- shadow model ----------------

    function automatic int eff_w();
        return (scr_w > MAX_W) ? MAX_W : int'(scr_w);
    endfunction

    function automatic int eff_h();
        return (scr_h > MAX_H) ? MAX_H : int'(scr_h);
    endfunction

    function automatic bit visible(int x, int y);
        return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
    endfunction

    function automatic logic [7:0] pix_bit(int x);
        return 8'h80 >> (x & 7);
    endfunction

    function automatic void plot(int x, int y, bit lit);
        int idx;
        if (!visible(x, y))
            return;
        idx = y * ROW_BYTES + (x >> 3);
        if (lit)
            shadow_fb[idx] = shadow_fb[idx] & ~pix_bit(x);
        else
            shadow_fb[idx] = shadow_fb[idx] | pix_bit(x);
    endfunction

    // midpoint stepping along the longer axis; clipped pixels still step
    function automatic void raster_line(int xa, int ya, int xb, int yb, bit lit);
        int dx;
        int dy;
        int sx;
        int sy;
        int d;
        int inc_s;
        int inc_d;
        dx = xb - xa;
        dy = yb - ya;
        sx = 1;
        sy = 1;
        if (dx < 0) begin
            sx = -1;
            dx = -dx;
        end
        if (dy < 0) begin
            sy = -1;
            dy = -dy;
        end
        plot(xa, ya, lit);
        if (dx >= dy) begin
            d = 2 * dy - dx;
            inc_s = 2 * dy;
            inc_d = 2 * (dy - dx);
            while (xa != xb) begin
                if (d <= 0) begin
                    d += inc_s;
                end else begin
                    d += inc_d;
                    ya += sy;
                end
                xa += sx;
                plot(xa, ya, lit);
            end
        end else begin
            d = 2 * dx - dy;
            inc_s = 2 * dx;
            inc_d = 2 * (dx - dy);
            while (ya != yb) begin
                if (d <= 0) begin
                    d += inc_s;
                end else begin
                    d += inc_d;
                    xa += sx;
                end
                ya += sy;
                plot(xa, ya, lit);
            end
        end
    endfunction

    // apply one command to the shadow buffer and return its result word
    function automatic t_px_word predict_word(logic [OP_W-1:0] op, t_coord xs, t_coord ys,
                                              t_coord xe, t_coord ye, logic pen);
        t_px_word w;
        int       idx;
        w = '0;
        case (op)
            OP_READ: begin
                if (!visible(int'(xs), int'(ys))) begin
                    w.off = 1'b1;
                end else begin
                    idx = int'(ys) * ROW_BYTES + (int'(xs) >> 3);
                    w.lit = (shadow_fb[idx] & pix_bit(int'(xs))) == 8'h00;
                end
            end
            OP_LINE: raster_line(int'(xs), int'(ys), int'(xe), int'(ye), pen);
            OP_FILL: begin
                // whole rows, so bits past the width in use change too
                for (int i = 0; i < eff_h() * ROW_BYTES; i++)
                    shadow_fb[i] = pen ? 8'h00 : 8'hFF;
            end
            default: ;
        endcase
        return w;
    endfunction

    // ---------------- drivers ----------------

    // drive one command word and wait for it to be taken
    task automatic issue_cmd(input logic [OP_W-1:0] op, input t_coord xs, input t_coord ys,
                             input t_coord xe, input t_coord ye, input logic pen,
                             input bit typed, input t_px_word typed_word);
        t_px_word w;
        @(negedge i_clk);
        start       = 1'b1;
        i_op        = op;
        i_x_start   = xs;
        i_y_start   = ys;
        i_x_end     = xe;
        i_y_end     = ye;
        i_pen_color = pen;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        w = predict_word(op, xs, ys, xe, ye, pen);
        pending_words.push_back(typed ? typed_word : w);
        case (op)
            OP_READ: n_reads++;
            OP_LINE: n_lines++;
            OP_FILL: n_fills++;
            default: n_spare++;
        endcase
    endtask

    // drop start and stay idle
    task automatic rest(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // hold off until every outstanding word has come back
    task automatic drain();
        rest(1);
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (idx == REG_WIDTH)
            scr_w = 32'(val[SW_W-1:0]);
        else
            scr_h = 32'(val[SH_W-1:0]);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // mostly near the screen, now and then anywhere in the 12-bit range
    function automatic t_coord pick_coord(int span);
        if ($urandom_range(0, 24) == 0)
            return t_coord'($urandom_range(0, 4095));
        return t_coord'(int'($urandom_range(0, span + 15)) - 8);
    endfunction

    task automatic random_cmd();
        int          r;
        logic [OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = OP_READ;
        else if (r < 93)
            op = OP_LINE;
        else if (r < 96)
            op = OP_FILL;
        else
            op = OP_SPARE;
        issue_cmd(op, pick_coord(eff_w()), pick_coord(eff_h()), pick_coord(eff_w()),
                  pick_coord(eff_h()), 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    // ---------------- result check ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (pending_words.size() == 0) begin
                $error("result word with none expected: lit=%0b off=%0b",
                       o_pixel_lit, o_off_screen);
                n_err++;
            end else begin
                head_word = pending_words.pop_front();
                if (o_pixel_lit !== head_word.lit) begin
                    $error("pixel_lit: expected %0b, got %0b", head_word.lit, o_pixel_lit);
                    n_err++;
                end
                if (o_off_screen !== head_word.off) begin
                    $error("off_screen: expected %0b, got %0b", head_word.off, o_off_screen);
                    n_err++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        int          n;
        int          burst;
        int          mode;
        t_px_word    tw;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = OP_READ;
        i_x_start   = '0;
        i_y_start   = '0;
        i_x_end     = '0;
        i_y_end     = '0;
        i_pen_color = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        n_err       = 0;
        n_results   = 0;
        cycle_cnt   = 0;
        n_reads     = 0;
        n_lines     = 0;
        n_fills     = 0;
        n_spare     = 0;
        scr_w       = 32'(SW_RESET);
        scr_h       = 32'(SH_RESET);
        for (int i = 0; i < FB_BYTES; i++)
            shadow_fb[i] = 8'hFF;

        // directed commands on the reset screen of 32 x 16
        plan = '{
            '{OP_READ,      0,     0,    0,    0, 1'b0, 1'b1, 1'b0, 1'b0},
            '{OP_READ,     31,    15,    0,    0, 1'b0, 1'b1, 1'b0, 1'b0},
            '{OP_READ,     32,     0,    0,    0, 1'b0, 1'b1, 1'b0, 1'b1},
            '{OP_READ,      0,    16,    0,    0, 1'b0, 1'b1, 1'b0, 1'b1},
            '{OP_READ,     -1,     0,    0,    0, 1'b0, 1'b1, 1'b0, 1'b1},
            '{OP_READ,  -2048,  2047,    0,    0, 1'b1, 1'b1, 1'b0, 1'b1},
            '{OP_READ,   2047, -2048,    0,    0, 1'b0, 1'b1, 1'b0, 1'b1},
            '{OP_LINE,      0,     0,   31,   15, 1'b1, 1'b1, 1'b0, 1'b0},
            '{OP_READ,      0,     0,    0,    0, 1'b0, 1'b1, 1'b1, 1'b0},
            '{OP_READ,     31,    15,    0,    0, 1'b0, 1'b1, 1'b1, 1'b0},
            '{OP_LINE,      5,     0,    7,   15, 1'b1, 1'b0, 1'b0, 1'b0},
            '{OP_LINE,     30,     2,    2,    5, 1'b0, 1'b0, 1'b0, 1'b0},
            '{OP_LINE,     10,    10,   10,   10, 1'b1, 1'b1, 1'b0, 1'b0},
            '{OP_READ,     10,    10,    0,    0, 1'b0, 1'b1, 1'b1, 1'b0},
            '{OP_LINE,     -5,    -3,   40,   20, 1'b1, 1'b0, 1'b0, 1'b0},
            '{OP_LINE,  -2048, -2048, 2047, 2047, 1'b0, 1'b0, 1'b0, 1'b0},
            '{OP_LINE,   2047, -2048, -2048, 2047, 1'b1, 1'b0, 1'b0, 1'b0},
            '{OP_READ,     16,     8,    0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{OP_FILL,      0,     0,    0,    0, 1'b1, 1'b1, 1'b0, 1'b0},
            '{OP_READ,     31,    15,    0,    0, 1'b0, 1'b1, 1'b1, 1'b0},
            '{OP_SPARE,    -1,    -1,   -1,   -1, 1'b1, 1'b1, 1'b0, 1'b0},
            '{OP_READ,      3,     3,    0,    0, 1'b0, 1'b1, 1'b1, 1'b0},
            '{OP_FILL,      0,     0,    0,    0, 1'b0, 1'b1, 1'b0, 1'b0},
            '{OP_READ,      0,     0,    0,    0, 1'b0, 1'b1, 1'b0, 1'b0},
            '{OP_LINE,      0,     5,   31,    5, 1'b1, 1'b0, 1'b0, 1'b0},
            '{OP_READ,     12,     5,    0,    0, 1'b0, 1'b0, 1'b0, 1'b0}
        };

        // screen sizes for the random phases, extremes first
        phase_w = '{256, 1, 511, 0, 200, 77};
        phase_h = '{64, 1, 127, 5, 0, 40};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part; the block may still be clearing its memory
        foreach (plan[i]) begin
            tw.lit = plan[i].lit;
            tw.off = plan[i].off;
            issue_cmd(plan[i].op, t_coord'(plan[i].xs), t_coord'(plan[i].ys),
                      t_coord'(plan[i].xe), t_coord'(plan[i].ye), plan[i].pen,
                      plan[i].typed, tw);
            if ($urandom_range(0, 2) == 0)
                rest($urandom_range(1, 6));
        end

        // random phases, one screen size each
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_reg(REG_WIDTH, CFG_DATA_W'({$urandom, 9'h0}) | CFG_DATA_W'(phase_w[p]));
            write_reg(REG_HEIGHT, CFG_DATA_W'({$urandom, 7'h0}) | CFG_DATA_W'(phase_h[p]));
            n = 0;
            while (n < PHASE_CMDS) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && n < PHASE_CMDS; b++) begin
                    random_cmd();
                    n++;
                end
                mode = $urandom_range(0, 49);
                if (mode == 0)
                    drain();
                else if (mode > 15)
                    rest($urandom_range(1, 40));
                // otherwise the next burst follows back to back
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d commands (%0d reads, %0d lines, %0d fills, %0d spare op)",
                 n_reads + n_lines + n_fills + n_spare, n_reads, n_lines, n_fills, n_spare);
        $display("tb_top: %0d screen sizes, %0d result words checked, %0d mismatches",
                 N_PHASES + 1, n_results, n_err);
        if (n_err == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
